@@ design/paae_pkg.sv @@
// Package: widths, fixed-point constants, CORDIC table and pipeline types for the block.
`default_nettype none

package paae_pkg;

   // angle format
   localparam int ANGLE_BITS = 24;
   localparam int SHIFT_BITS = 32 - ANGLE_BITS;
   localparam logic [31:0] ROUND_HALF = 32'((64'd1 << SHIFT_BITS) >> 1);

   // configuration port
   localparam int CSR_BITS = 18;
   localparam logic CSR_SIN_LAT = 1'b0;
   localparam logic CSR_COS_LAT = 1'b1;

   // CORDIC constants
   localparam int SC_STAGES = 31;
   localparam int AT_STAGES = 32;
   localparam int SQ_STAGES = 31;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [37:0] ONE_Q30 = 38'sd1073741824;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // rotation-mode CORDIC state (Q2.30)
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [1:0]         q;
   } sc_type;

   // vectoring-mode CORDIC state
   typedef struct packed {
      logic signed [37:0] x;
      logic signed [37:0] y;
      logic [31:0]        z;
      logic               zero;
   } at_type;

endpackage

`default_nettype wire

@@ design/paae_if.sv @@
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none

interface paae_req_if;
   import paae_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] polar_angle;
   logic [ANGLE_BITS-1:0] pole_distance;
   modport source (output valid, output polar_angle, output pole_distance, input ready);
   modport sink (input valid, input polar_angle, input pole_distance, output ready);
endinterface

interface paae_rsp_if;
   import paae_pkg::*;
   logic                         valid;
   logic                         ready;
   logic        [ANGLE_BITS-1:0] azimuth;
   logic signed [ANGLE_BITS-1:0] elevation;
   modport source (output valid, output azimuth, output elevation, input ready);
   modport sink (input valid, input azimuth, input elevation, output ready);
endinterface

`default_nettype wire

@@ design/polar_axis_to_azimuth_elevation_top.sv @@
// Top level: polar-axis/pole-distance to azimuth/elevation conversion pipeline.
// One beat is accepted per cycle unless the sink stalls, and one result beat comes out per
// input, in order. Stages: input fold, 31 rotation CORDIC stages (sine and cosine of both
// angles side by side), rounding, two multiplier stages, sum/clamp, squaring, 31 square
// root stages and 33 vectoring CORDIC stages (elevation and azimuth side by side), then the
// output register. The whole pipe advances together whenever the output register is empty
// or being taken, so a stalled sink holds every stage. The latitude registers must only be
// written while the pipe is empty.
`default_nettype none

module polar_axis_to_azimuth_elevation_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   paae_req_if.sink                            req_ch,
   paae_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic                           csr_index,
   input  wire logic [paae_pkg::CSR_BITS-1:0]  csr_data
);
   import paae_pkg::*;

   // rotation CORDIC step
   function automatic sc_type sc_step(input sc_type s, input int i);
      sc_type o;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] at;
      dx = s.y >>> i;
      dy = s.x >>> i;
      at = $signed({2'b00, ATAN_TAB[i]});
      o.q = s.q;
      if (!s.z[33]) begin
         o.x = s.x - dx;
         o.y = s.y + dy;
         o.z = s.z - at;
      end else begin
         o.x = s.x + dx;
         o.y = s.y - dy;
         o.z = s.z + at;
      end
      return o;
   endfunction

   // vectoring CORDIC step
   function automatic at_type at_step(input at_type s, input int i);
      at_type o;
      logic signed [37:0] dx;
      logic signed [37:0] dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      o.zero = s.zero;
      if (s.y > 38'sd0) begin
         o.x = s.x + dx;
         o.y = s.y - dy;
         o.z = s.z + ATAN_TAB[i];
      end else begin
         o.x = s.x - dx;
         o.y = s.y + dy;
         o.z = s.z - ATAN_TAB[i];
      end
      return o;
   endfunction

   // fold a binary angle to within 45 degrees of a quadrant axis
   function automatic sc_type sc_fold(input logic [ANGLE_BITS-1:0] ang);
      sc_type o;
      logic [31:0] a;
      logic [31:0] d;
      a = 32'(ang) << SHIFT_BITS;
      o.q = 2'((a + 32'h2000_0000) >> 30);
      d = a - {o.q, 30'b0};
      o.x = CORDIC_GAIN;
      o.y = '0;
      o.z = 34'($signed(d));
      return o;
   endfunction

   // round Q2.30 to Q1.16
   function automatic logic signed [17:0] rnd14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd8192) >>> 14;
      return t[17:0];
   endfunction

   function automatic logic signed [37:0] rnd18(input logic signed [55:0] v);
      logic signed [55:0] t;
      t = (v + 56'sd131072) >>> 18;
      return t[37:0];
   endfunction

   // vectoring pre-rotation into the right half plane
   function automatic at_type at_pre(input logic signed [37:0] y, input logic signed [37:0] x);
      at_type o;
      o.zero = (x == '0) && (y == '0);
      o.x = x;
      o.y = y;
      o.z = '0;
      if (x < 38'sd0) begin
         if (y >= 38'sd0) begin
            o.x = y;
            o.y = -x;
            o.z = 32'h4000_0000;
         end else begin
            o.x = -y;
            o.y = x;
            o.z = 32'hC000_0000;
         end
      end
      return o;
   endfunction

   // configuration registers
   logic signed [17:0] sin_lat_ff;
   logic signed [17:0] cos_lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_lat_ff <= '0;
         cos_lat_ff <= 18'sd65536;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIN_LAT: sin_lat_ff <= $signed(csr_data);
            CSR_COS_LAT: cos_lat_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // global advance: output register empty or being taken
   logic en;
   logic rsp_vld_ff;
   assign en = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // sine/cosine CORDIC for both angles
   sc_type sc_p_ff [0:SC_STAGES];
   sc_type sc_g_ff [0:SC_STAGES];
   logic   vsc_ff  [0:SC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         sc_p_ff[0] <= sc_fold(req_ch.polar_angle);
         sc_g_ff[0] <= sc_fold(req_ch.pole_distance);
      end
   end

   for (genvar i = 0; i < SC_STAGES; i++) begin : g_sc
      always_ff @(posedge clock) begin
         if (en) begin
            sc_p_ff[i+1] <= sc_step(sc_p_ff[i], i);
            sc_g_ff[i+1] <= sc_step(sc_g_ff[i], i);
         end
      end
   end

   // quadrant restore and rounding
   logic signed [17:0] sp_ff, cp_ff, sg_ff, cg_ff;
   logic               vpost_ff;
   logic signed [33:0] spx, spy, sgx, sgy;

   always_comb begin
      spx = sc_p_ff[SC_STAGES].x;
      spy = sc_p_ff[SC_STAGES].y;
      unique case (sc_p_ff[SC_STAGES].q)
         2'd1: begin spx = -sc_p_ff[SC_STAGES].y; spy = sc_p_ff[SC_STAGES].x; end
         2'd2: begin spx = -sc_p_ff[SC_STAGES].x; spy = -sc_p_ff[SC_STAGES].y; end
         2'd3: begin spx = sc_p_ff[SC_STAGES].y; spy = -sc_p_ff[SC_STAGES].x; end
         default: ;
      endcase
      sgx = sc_g_ff[SC_STAGES].x;
      sgy = sc_g_ff[SC_STAGES].y;
      unique case (sc_g_ff[SC_STAGES].q)
         2'd1: begin sgx = -sc_g_ff[SC_STAGES].y; sgy = sc_g_ff[SC_STAGES].x; end
         2'd2: begin sgx = -sc_g_ff[SC_STAGES].x; sgy = -sc_g_ff[SC_STAGES].y; end
         2'd3: begin sgx = sc_g_ff[SC_STAGES].y; sgy = -sc_g_ff[SC_STAGES].x; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff <= rnd14(spy);
         cp_ff <= rnd14(spx);
         sg_ff <= rnd14(sgy);
         cg_ff <= rnd14(sgx);
      end
   end

   // first products
   logic signed [35:0] cgsl_ff, cpsg_ff, cgcl_ff, spsg_ff;
   logic               vma_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cgsl_ff <= cg_ff * sin_lat_ff;
         cpsg_ff <= cp_ff * sg_ff;
         cgcl_ff <= cg_ff * cos_lat_ff;
         spsg_ff <= sp_ff * sg_ff;
      end
   end

   // three-factor products
   logic signed [53:0] t_cl_ff, t_sl_ff;
   logic signed [35:0] cgsl2_ff, cgcl2_ff, spsg2_ff;
   logic               vmb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_cl_ff  <= cpsg_ff * cos_lat_ff;
         t_sl_ff  <= cpsg_ff * sin_lat_ff;
         cgsl2_ff <= cgsl_ff;
         cgcl2_ff <= cgcl_ff;
         spsg2_ff <= spsg_ff;
      end
   end

   // sums, Q30 rounding and elevation-sine clamp
   logic signed [37:0] se_raw, east_c, north_c;
   logic signed [31:0] se_ff;
   logic signed [37:0] east_ff, north_ff;
   logic               vsum_ff;

   always_comb begin
      se_raw  = rnd18((56'(cgsl2_ff) <<< 16) - 56'(t_cl_ff));
      east_c  = rnd18(-(56'(spsg2_ff) <<< 16));
      north_c = rnd18((56'(cgcl2_ff) <<< 16) + 56'(t_sl_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         priority if (se_raw > ONE_Q30) se_ff <= 32'(ONE_Q30);
         else if (se_raw < -ONE_Q30)    se_ff <= 32'(-ONE_Q30);
         else                           se_ff <= se_raw[31:0];
         east_ff  <= east_c;
         north_ff <= north_c;
      end
   end

   // square root pipeline: cosine of elevation = sqrt(2^60 - se^2)
   logic [61:0]        sq_n_ff  [0:SQ_STAGES];
   logic [61:0]        sq_r_ff  [0:SQ_STAGES];
   logic signed [31:0] sq_se_ff [0:SQ_STAGES];
   logic signed [37:0] sq_e_ff  [0:SQ_STAGES];
   logic signed [37:0] sq_no_ff [0:SQ_STAGES];
   logic               vsq_ff   [0:SQ_STAGES];
   logic signed [63:0] se_sq;

   assign se_sq = se_ff * se_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0]  <= (62'd1 << 60) - se_sq[61:0];
         sq_r_ff[0]  <= '0;
         sq_se_ff[0] <= se_ff;
         sq_e_ff[0]  <= east_ff;
         sq_no_ff[0] <= north_ff;
      end
   end

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      localparam logic [61:0] BIT_K = 62'd1 << (2 * (SQ_STAGES - 1 - k));
      logic [61:0] trial;
      assign trial = sq_r_ff[k] + BIT_K;
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_n_ff[k] >= trial) begin
               sq_n_ff[k+1] <= sq_n_ff[k] - trial;
               sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT_K;
            end else begin
               sq_n_ff[k+1] <= sq_n_ff[k];
               sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
            end
            sq_se_ff[k+1] <= sq_se_ff[k];
            sq_e_ff[k+1]  <= sq_e_ff[k];
            sq_no_ff[k+1] <= sq_no_ff[k];
         end
      end
   end

   // atan2 pipelines for elevation and azimuth
   at_type at_e_ff [0:AT_STAGES];
   at_type at_a_ff [0:AT_STAGES];
   logic   vat_ff  [0:AT_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         at_e_ff[0] <= at_pre(38'(sq_se_ff[SQ_STAGES]), 38'(sq_r_ff[SQ_STAGES]));
         at_a_ff[0] <= at_pre(sq_e_ff[SQ_STAGES], sq_no_ff[SQ_STAGES]);
      end
   end

   for (genvar i = 0; i < AT_STAGES; i++) begin : g_at
      always_ff @(posedge clock) begin
         if (en) begin
            at_e_ff[i+1] <= at_step(at_e_ff[i], i);
            at_a_ff[i+1] <= at_step(at_a_ff[i], i);
         end
      end
   end

   // round to output width and register
   logic [31:0] az32, el32, az_rnd, el_rnd;
   logic        [ANGLE_BITS-1:0] az_ff;
   logic signed [ANGLE_BITS-1:0] el_ff;

   always_comb begin
      az32 = at_a_ff[AT_STAGES].zero ? 32'd0 : at_a_ff[AT_STAGES].z;
      el32 = at_e_ff[AT_STAGES].zero ? 32'd0 : at_e_ff[AT_STAGES].z;
      az_rnd = az32 + ROUND_HALF;
      el_rnd = el32 + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         az_ff <= az_rnd[31:SHIFT_BITS];
         el_ff <= $signed(el_rnd[31:SHIFT_BITS]);
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= SC_STAGES; s++) vsc_ff[s] <= 1'b0;
         for (int s = 0; s <= SQ_STAGES; s++) vsq_ff[s] <= 1'b0;
         for (int s = 0; s <= AT_STAGES; s++) vat_ff[s] <= 1'b0;
         vpost_ff   <= 1'b0;
         vma_ff     <= 1'b0;
         vmb_ff     <= 1'b0;
         vsum_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vsc_ff[0] <= req_ch.valid;
         for (int s = 1; s <= SC_STAGES; s++) vsc_ff[s] <= vsc_ff[s-1];
         vpost_ff  <= vsc_ff[SC_STAGES];
         vma_ff    <= vpost_ff;
         vmb_ff    <= vma_ff;
         vsum_ff   <= vmb_ff;
         vsq_ff[0] <= vsum_ff;
         for (int s = 1; s <= SQ_STAGES; s++) vsq_ff[s] <= vsq_ff[s-1];
         vat_ff[0] <= vsq_ff[SQ_STAGES];
         for (int s = 1; s <= AT_STAGES; s++) vat_ff[s] <= vat_ff[s-1];
         rsp_vld_ff <= vat_ff[AT_STAGES];
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.azimuth   = az_ff;
   assign rsp_ch.elevation = el_ff;

   // checks
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vsc_ff[0])
      else $error("accepted beat did not enter the pipe");

   a_se_clamped : assert property (@(posedge clock) disable iff (reset)
      vsq_ff[0] |-> (sq_se_ff[0] <= 32'(ONE_Q30)) && (sq_se_ff[0] >= 32'(-ONE_Q30)))
      else $error("elevation sine outside clamp");

   a_sqrt_range : assert property (@(posedge clock) disable iff (reset)
      vsq_ff[SQ_STAGES] |-> sq_r_ff[SQ_STAGES] <= 62'(ONE_Q30))
      else $error("square root above unity");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vat_ff[AT_STAGES]) && $stable(at_a_ff[AT_STAGES]))
      else $error("pipe moved during a stall");

endmodule

`default_nettype wire

@@ verif/tb_polar_axis_to_azimuth_elevation_top.sv @@
// Testbench: random and directed pointing conversions checked against a bit-true predictor.
`default_nettype none

module tb_polar_axis_to_azimuth_elevation_top;
   import paae_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_CYCLES = 110;
   localparam int N_PHASES    = 7;
   localparam int RAND_ITEMS  = 264;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] polar_angle;
      logic [ANGLE_BITS-1:0] pole_distance;
   } pointing_type;

   typedef struct packed {
      logic        [ANGLE_BITS-1:0] azimuth;
      logic signed [ANGLE_BITS-1:0] elevation;
   } horizon_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_SIN_LAT;
   logic [CSR_BITS-1:0] csr_data = '0;

   paae_req_if req_ch ();
   paae_rsp_if rsp_ch ();

   polar_axis_to_azimuth_elevation_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pointing_type pending_pointings[$];
   horizon_type  awaited_horizons[$];
   longint       site_sin, site_cos;
   bit           calm_sender, calm_receiver;
   bit           beat_taken;
   int           mismatches;

   // arctangent table, 32-bit binary angle per CORDIC stage
   localparam longint ARCTAN [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000
   };

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sext_csr(logic [CSR_BITS-1:0] v);
      return longint'(signed'(v));
   endfunction

   // sine and cosine in Q1.16 from a folded rotation CORDIC
   function automatic void sine_cosine(input logic [31:0] a, output longint s, output longint c);
      logic [1:0]  q;
      logic [31:0] d;
      longint      x, y, z, t, dx, dy;
      q = 2'((a + 32'h20000000) >> 30);
      d = a - {q, 30'b0};
      z = longint'(signed'(d));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 31; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      unique case (q)
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      s = round_shift(y, 14);
      c = round_shift(x, 14);
   endfunction

   // bearing of (x, y) as a 32-bit binary angle, vectoring CORDIC
   function automatic logic [31:0] bearing(longint y, longint x);
      logic [31:0] z;
      longint      t, dx, dy;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 32'h40000000;
         end else begin
            t = x; x = -y; y = t; z = 32'hC0000000;
         end
      end
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += 32'(ARCTAN[i]);
         end else begin
            x -= dx; y += dy; z -= 32'(ARCTAN[i]);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // azimuth and elevation for one pointing at the current site latitude
   function automatic horizon_type to_horizon(pointing_type p);
      longint sp, cp, sg, cg, se, ce, east, north, el32;
      logic [31:0] el_bin, az32;
      horizon_type h;
      sine_cosine({p.polar_angle, 8'b0}, sp, cp);
      sine_cosine({p.pole_distance, 8'b0}, sg, cg);
      se = round_shift(cg * site_sin * 65536 - cp * sg * site_cos, 18);
      if (se > (longint'(1) << 30)) se = longint'(1) << 30;
      if (se < -(longint'(1) << 30)) se = -(longint'(1) << 30);
      ce = longint'(floor_sqrt((longint'(1) << 60) - se * se));
      el_bin = bearing(se, ce);
      el32 = longint'(signed'(el_bin));
      east = round_shift(-sp * sg * 65536, 18);
      north = round_shift(cg * site_cos * 65536 + cp * sg * site_sin, 18);
      az32 = bearing(east, north);
      h.azimuth = 24'((longint'(az32) + 128) >> 8);
      h.elevation = 24'((el32 + 128) >>> 8);
      return h;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver: beats change on the falling edge
   int send_gap = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.polar_angle = '0;
      req_ch.pole_distance = '0;
   end

   always @(negedge clock) begin
      pointing_type nxt;
      if (!reset && !(req_ch.valid && !beat_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_pointings.size() > 0) begin
            nxt = pending_pointings.pop_front();
            req_ch.polar_angle <= nxt.polar_angle;
            req_ch.pole_distance <= nxt.pole_distance;
            req_ch.valid <= 1'b1;
            send_gap = calm_sender ? 0 : gap_len();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink: random back-pressure
   int hold_gap = 0;
   initial rsp_ch.ready = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         hold_gap = calm_receiver ? 0 : gap_len();
      end
   end

   // monitor: latitude copy, accepted beats and result checks
   always @(posedge clock) begin
      horizon_type want;
      beat_taken = 1'b0;
      if (csr_wr_en) begin
         if (csr_index == CSR_SIN_LAT) site_sin = sext_csr(csr_data);
         else site_cos = sext_csr(csr_data);
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         beat_taken = 1'b1;
         awaited_horizons.push_back(to_horizon({req_ch.polar_angle, req_ch.pole_distance}));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_horizons.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result az=%h el=%h", $time,
                     rsp_ch.azimuth, rsp_ch.elevation);
         end else begin
            want = awaited_horizons.pop_front();
            if (rsp_ch.azimuth !== want.azimuth) begin
               mismatches++;
               $display("%0t: azimuth expected %h actual %h", $time,
                        want.azimuth, rsp_ch.azimuth);
            end
            if (rsp_ch.elevation !== want.elevation) begin
               mismatches++;
               $display("%0t: elevation expected %h actual %h", $time,
                        want.elevation, rsp_ch.elevation);
            end
         end
      end
   end

   task automatic write_latitude(logic signed [CSR_BITS-1:0] s, logic signed [CSR_BITS-1:0] c);
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= CSR_SIN_LAT; csr_data <= s;
      @(negedge clock);
      csr_index <= CSR_COS_LAT; csr_data <= c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_pointings.size() > 0 || req_ch.valid || awaited_horizons.size() > 0)
         @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_pointing(int unsigned pa, int unsigned pd);
      pending_pointings.push_back({24'(pa), 24'(pd)});
   endfunction

   // stimulus: several site latitudes, each with a few fixed beats and then random ones
   initial begin
      logic signed [CSR_BITS-1:0] lat_sin [N_PHASES];
      logic signed [CSR_BITS-1:0] lat_cos [N_PHASES];
      int unsigned pd;
      mismatches = 0;
      site_sin = 0;
      site_cos = 65536;
      lat_sin = '{0, 46341, 65536, -65536, -46341, 131071, 18'($urandom)};
      lat_cos = '{65536, 46341, 0, 0, -46341, -131072, 18'($urandom)};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         // sender holds off until the pipe has emptied before each latitude change
         wait_drained();
         write_latitude(lat_sin[ph], lat_cos[ph]);
         calm_sender = (ph % 3 == 2);
         calm_receiver = (ph % 3 == 1);
         queue_pointing(0, 0);
         queue_pointing(12345, 8388608);
         queue_pointing(1, 4194304);
         if (ph == 0) begin
            // angle extremes, quadrant boundaries and pole distance past half a circle
            queue_pointing(24'hFFFFFF, 24'hFFFFFF);
            queue_pointing(24'hFFFFFF, 0);
            queue_pointing(0, 8388608);
            queue_pointing(4194304, 4194304);
            queue_pointing(8388608, 2097152);
            queue_pointing(12582912, 6291456);
            queue_pointing(2097152, 12582912);
            queue_pointing(24'hFFFFFF, 4194304);
            queue_pointing(24'h800001, 24'h7FFFFF);
            queue_pointing(24'h555555, 24'hAAAAAA);
            queue_pointing(24'hAAAAAA, 24'h555555);
         end
         for (int k = 0; k < RAND_ITEMS; k++) begin
            pd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                              : $urandom_range(0, 8388608);
            queue_pointing($urandom_range(0, 24'hFFFFFF), pd);
         end
      end
      wait_drained();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // overall time limit
   initial begin
      #8ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
